// ===== rtl/core/utcl_pkg.sv =====
// Shared types, constants and calendar helpers for the UTC to local minutes core.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package utcl_pkg;

    // Offset coding: biased by twelve hours, valid below twenty-six hours
    localparam logic [10:0] OFS_LIMIT = 11'(26 * 60);
    localparam logic [10:0] OFS_BIAS  = 11'(12 * 60);
    localparam logic [31:0] DST_MIN   = 32'd60;

    localparam int unsigned EPOCH_YEAR_DEF = 2000;
    localparam int unsigned ERA_YEARS_DEF  = 16;

    // Reciprocals for exact division by constants over the stated input widths
    localparam logic [27:0] RECIP_10K  = 28'd219902326;  // x / 10000, x < 2**27, shift 41
    localparam logic [27:0] RECIP_45   = 28'd190887436;  // x / 45, x < 2**27, shift 33
    localparam logic [16:0] RECIP_1461 = 17'd91868;      // x / 1461, x < 2**16, shift 27
    localparam logic [13:0] DEC_10K    = 14'd10000;
    localparam logic [15:0] DAYS_4Y    = 16'd1461;
    localparam logic [10:0] MMDD_LAST  = 11'd1231;

    localparam int unsigned DAY_W    = 22;  // 2**32 minutes / 1440
    localparam int unsigned CYC_W    = 16;  // day index inside the era plus alignment
    localparam int unsigned DATE_LAT = 6;   // day index in to mmdd out
    localparam int unsigned PIPE_LAT = DATE_LAT + 3;

    typedef struct packed {
        logic [31:0] utc_minutes;
        logic [10:0] zone_offset;
        logic [10:0] local_offset;
        logic [26:0] dst_window;
    } utcl_cmd_t;

    typedef struct packed {
        logic [31:0] local_minutes;
        logic        before_epoch;
        logic        dst_applied;
    } utcl_rsp_t;

    // Total days in the era, all years on the divisible-by-4 rule
    function automatic int unsigned era_days(input int unsigned epoch, input int unsigned era);
        int unsigned sum;
        sum = 0;
        for (int unsigned y = 0; y < era; y++)
        begin
            sum += (((epoch + y) % 4) == 0) ? 366 : 365;
        end
        return sum;
    endfunction

    // Days from the start of the leap year at or before the epoch to the epoch
    function automatic int unsigned phase_days(input int unsigned epoch);
        int unsigned p;
        p = epoch % 4;
        return (p == 0) ? 0 : 366 + 365 * (p - 1);
    endfunction

    // Day of year on which month m (0 = January) starts
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
        logic [8:0] base;
        case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + {8'd0, (leap && (m >= 4'd2))};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/utcl_date.sv =====
// Pipelined day index to decimal mmdd conversion, clamped to the era's last day.
// Depends on utcl_pkg for reciprocal constants and the month table.
`default_nettype none

module utcl_date #(
    parameter int unsigned EPOCH_YEAR = utcl_pkg::EPOCH_YEAR_DEF,
    parameter int unsigned ERA_YEARS  = utcl_pkg::ERA_YEARS_DEF
) (
    input  logic                      clk,
    input  logic [utcl_pkg::DAY_W-1:0] day,
    output logic [10:0]               mmdd
);
    import utcl_pkg::*;

    localparam int unsigned ERA_DAYS = era_days(EPOCH_YEAR, ERA_YEARS);
    localparam int unsigned PHASE    = phase_days(EPOCH_YEAR);

    logic             clamp_a_reg, clamp_b_reg, clamp_c_reg, clamp_d_reg, clamp_e_reg;
    logic [CYC_W-1:0] dp_a_reg, dp_b_reg;
    logic [32:0]      cprod_b_reg;
    logic [10:0]      rem_c_reg;
    logic             leap_d_reg;
    logic [8:0]       doy_d_reg;
    logic [3:0]       m_e_reg;
    logic [4:0]       dom_e_reg;
    logic [10:0]      mmdd_reg;

    logic [5:0]       cyc;
    logic [10:0]      rem_next;
    logic [8:0]       doy_next;
    logic [3:0]       m_next;
    logic [4:0]       dom_next;
    logic [10:0]      mmdd_next;

    always_comb
    begin
        cyc      = cprod_b_reg[32:27];
        rem_next = 11'(dp_b_reg - {10'd0, cyc} * DAYS_4Y);

        // First year of each four-year cycle is the leap year
        if (rem_c_reg < 11'd366)
            doy_next = rem_c_reg[8:0];
        else if ((rem_c_reg - 11'd366) < 11'd365)
            doy_next = 9'(rem_c_reg - 11'd366);
        else if ((rem_c_reg - 11'd366) < 11'd730)
            doy_next = 9'(rem_c_reg - 11'd731);
        else
            doy_next = 9'(rem_c_reg - 11'd1096);

        m_next = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            m_next = m_next + {3'd0, (doy_d_reg >= month_start(leap_d_reg, 4'(k)))};
        end
        dom_next = 5'(doy_d_reg - month_start(leap_d_reg, m_next));

        if (clamp_e_reg)
            mmdd_next = MMDD_LAST;
        else
            mmdd_next = {7'd0, m_e_reg} * 11'd100 + 11'd101 + {6'd0, dom_e_reg};
    end

    always_ff @(posedge clk)
    begin
        clamp_a_reg <= (day >= DAY_W'(ERA_DAYS));
        dp_a_reg    <= day[CYC_W-1:0] + CYC_W'(PHASE);

        clamp_b_reg <= clamp_a_reg;
        dp_b_reg    <= dp_a_reg;
        cprod_b_reg <= {17'd0, dp_a_reg} * {16'd0, RECIP_1461};

        clamp_c_reg <= clamp_b_reg;
        rem_c_reg   <= rem_next;

        clamp_d_reg <= clamp_c_reg;
        leap_d_reg  <= (rem_c_reg < 11'd366);
        doy_d_reg   <= doy_next;

        clamp_e_reg <= clamp_d_reg;
        m_e_reg     <= m_next;
        dom_e_reg   <= dom_next;

        mmdd_reg    <= mmdd_next;
    end

    assign mmdd = mmdd_reg;

endmodule

`default_nettype wire

// ===== rtl/core/utc_to_local_minutes_dst_core.sv =====
// Throughput: one item per cycle; busy is held low, the pipeline never stalls.
// Stages: offset add, three reciprocal multiplies for the /10000, /1440 and
// /1461 divisions (utcl_date), month lookup, window compare and DST add.
// Reset clears the stage valid bits and done; data registers are not reset.
// Depends on utcl_pkg and utcl_date.
`default_nettype none

module utc_to_local_minutes_dst_core #(
    parameter int unsigned EPOCH_YEAR = utcl_pkg::EPOCH_YEAR_DEF,
    parameter int unsigned ERA_YEARS  = utcl_pkg::ERA_YEARS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  utcl_pkg::utcl_cmd_t cmd,
    output logic                done,
    output utcl_pkg::utcl_rsp_t rsp
);
    import utcl_pkg::*;

    typedef struct packed {
        logic [31:0] mins;
        logic        pre_epoch;
        logic        win;
        logic [13:0] wstart;
        logic [13:0] wend;
    } side_t;

    // Stage 1: offset applied, window product
    logic        v1_reg;
    logic [31:0] mins1_reg;
    logic        before1_reg, win1_reg;
    logic [26:0] window1_reg;
    logic [54:0] wprod1_reg;
    // Stage 2: window start, day product
    logic        v2_reg;
    logic [31:0] mins2_reg;
    logic        before2_reg, win2_reg;
    logic [26:0] window2_reg;
    logic [13:0] start2_reg;
    logic [54:0] dprod2_reg;
    // Stage 3 onward: side data waiting for the date pipeline
    logic        vd_reg [DATE_LAT];
    side_t       sb_reg [DATE_LAT];
    side_t       sb3_next;
    // Output
    logic        done_reg;
    utcl_rsp_t   rsp_reg;

    logic [10:0] ofs_sel;
    logic        pass;
    logic        before_next;
    logic [31:0] mins_next;
    logic [13:0] wend_next;
    logic [10:0] mmdd;
    side_t       sb_last;
    logic [13:0] md;
    logic        hit;

    utcl_date #(
        .EPOCH_YEAR(EPOCH_YEAR),
        .ERA_YEARS (ERA_YEARS)
    ) u_date (
        .clk (clk),
        .day (dprod2_reg[54:33]),
        .mmdd(mmdd)
    );

    always_comb
    begin
        ofs_sel     = (cmd.zone_offset >= OFS_LIMIT) ? cmd.local_offset : cmd.zone_offset;
        pass        = (ofs_sel >= OFS_LIMIT);
        before_next = !pass && (cmd.utc_minutes <= {21'd0, ofs_sel});
        if (pass || before_next)
            mins_next = cmd.utc_minutes;
        else
            mins_next = cmd.utc_minutes + {21'd0, ofs_sel} - {21'd0, OFS_BIAS};

        wend_next = 14'(window2_reg - {13'd0, start2_reg} * {13'd0, DEC_10K});

        sb3_next.mins      = mins2_reg;
        sb3_next.pre_epoch = before2_reg;
        sb3_next.win       = win2_reg && (start2_reg != 14'd0) && (wend_next != 14'd0);
        sb3_next.wstart    = start2_reg;
        sb3_next.wend      = wend_next;

        // Window may wrap the year end: start inclusive, end exclusive
        sb_last = sb_reg[DATE_LAT-1];
        md      = {3'd0, mmdd};
        if (sb_last.wstart < sb_last.wend)
            hit = sb_last.win && (md >= sb_last.wstart) && (md < sb_last.wend);
        else
            hit = sb_last.win && ((md < sb_last.wend) || (md >= sb_last.wstart));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i < DATE_LAT; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v1_reg    <= start;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            for (int i = 1; i < DATE_LAT; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
            done_reg  <= vd_reg[DATE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        mins1_reg   <= mins_next;
        before1_reg <= before_next;
        win1_reg    <= (cmd.zone_offset >= OFS_LIMIT) && !pass && !before_next;
        window1_reg <= cmd.dst_window;
        wprod1_reg  <= {28'd0, cmd.dst_window} * {27'd0, RECIP_10K};

        mins2_reg   <= mins1_reg;
        before2_reg <= before1_reg;
        win2_reg    <= win1_reg;
        window2_reg <= window1_reg;
        start2_reg  <= wprod1_reg[54:41];
        // Minutes / 1440 = (minutes / 32) / 45
        dprod2_reg  <= {28'd0, mins1_reg[31:5]} * {27'd0, RECIP_45};

        sb_reg[0]   <= sb3_next;
        for (int i = 1; i < DATE_LAT; i++)
        begin
            sb_reg[i] <= sb_reg[i-1];
        end

        rsp_reg.local_minutes <= hit ? (sb_last.mins + DST_MIN) : sb_last.mins;
        rsp_reg.before_epoch  <= sb_last.pre_epoch;
        rsp_reg.dst_applied   <= hit;
    end

    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTH
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LAT done)
        else $error("item accepted without a result at the fixed latency");

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LAT))
        else $error("result strobe without an accepted item");

    a_before_no_dst: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.before_epoch |-> !rsp.dst_applied)
        else $error("DST hour added to a time before the epoch");

    a_before_passes: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.before_epoch |-> rsp.local_minutes == $past(cmd.utc_minutes, PIPE_LAT))
        else $error("time before the epoch not passed through unchanged");
`endif

endmodule

`default_nettype wire
